// ===== sv/fsk_dec_pkg.sv =====
// ============================================================================
// fsk_dec_pkg
// Shared types, constants and helper functions for the distance-coded FSK
// symbol decoder.
// ============================================================================
package fsk_dec_pkg;

    localparam int DIST_WIDTH = 12;
    localparam int CMP_W      = (DIST_WIDTH > 9) ? DIST_WIDTH : 9;

    localparam int APB_AW = 5;
    localparam int APB_DW = 64;

    localparam logic [1:0] REG_FREQ_DISTANCES = 2'd0;
    localparam logic [1:0] REG_SYNC_DISTANCE  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE      = 2'd2;

    localparam logic [63:0] FREQ_DISTANCES_RST = 64'h2F2A_2621_1917_100C;
    localparam logic [7:0]  SYNC_DISTANCE_RST  = 8'd29;
    localparam logic [3:0]  TOLERANCE_RST      = 4'd1;

    localparam logic [3:0] CLASS_NONE = 4'd0;
    localparam logic [3:0] CLASS_SYNC = 4'd9;

    localparam logic [2:0] PHASE_WAIT_SYNC = 3'd0;
    localparam logic [2:0] PHASE_DIGIT_1   = 3'd1;
    localparam logic [2:0] PHASE_DIGIT_4   = 3'd4;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] exact_distance;
        logic [DIST_WIDTH-1:0] approx_distance;
    } t_in_item;

    typedef struct packed {
        logic [6:0] char_code;
        logic       range_error;
    } t_out_item;

    // True when v lies in [c - tol, c + tol], with the lower bound held at zero.
    function automatic logic in_window(input logic [DIST_WIDTH-1:0] v,
                                       input logic [7:0] c,
                                       input logic [3:0] tol);
        logic [8:0] hi;
        logic [7:0] lo;
        logic       lo_neg;
        hi     = {1'b0, c} + {5'b0, tol};
        lo     = c - {4'b0, tol};
        lo_neg = (c < {4'b0, tol});
        return (lo_neg || (CMP_W'(v) >= CMP_W'(lo))) && (CMP_W'(v) <= CMP_W'(hi));
    endfunction

    function automatic logic dist_equal(input logic [DIST_WIDTH-1:0] v,
                                        input logic [7:0] c);
        return CMP_W'(v) == CMP_W'(c);
    endfunction

endpackage

// ===== sv/fsk_distance_symbol_decoder.sv =====
// ============================================================================
// fsk_distance_symbol_decoder
// Sorts each frame's stripe distances into frequency classes, turns class
// changes into 2-bit digits and emits one 7-bit character per four digits.
// ============================================================================
// Usage:
// The input channel carries one frame's exact and approximate distance per
// transfer; the output channel carries a character and its range error flag,
// produced only when a fourth digit completes a symbol. Both channels use
// valid and stall; a transfer happens when valid is high and stall is low.
// An accepted item lands in an input register and is decoded from there
// into the result register once the output can take a new result. One item
// is taken every cycle unless the output is stalled while holding a result;
// the classifier and the symbol update sit in a single register-to-register path.
// When the output is stalled while holding a result, the item in the input
// register waits and the input channel is stalled until the result is taken;
// an empty input register can still take one more item.
// The APB port sets the class distances, the sync distance and the
// tolerance at byte addresses 0, 8 and 16; write it only while idle.
// Synchronous reset restores the register defaults, empties both registers
// and returns the decoder to waiting for the sync tone.
// ============================================================================
module fsk_distance_symbol_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fsk_dec_pkg::t_in_item         i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fsk_dec_pkg::t_out_item        o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsk_dec_pkg::APB_AW-1:0] paddr,
    input  logic [fsk_dec_pkg::APB_DW-1:0] pwdata,
    output logic [fsk_dec_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);
    import fsk_dec_pkg::*;

    logic [63:0] r_freq;
    logic [7:0]  r_sync;
    logic [3:0]  r_tol;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_acc,   n_acc;
    logic [3:0]  r_last,  n_last;

    logic        w_proc;
    logic        w_emit;
    logic        w_wr;
    logic [1:0]  w_reg_idx;
    logic [3:0]  w_class;
    logic [7:0]  w_sum;
    logic [2:0]  w_pos;
    logic [1:0]  w_digit;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:3];
    assign w_wr      = psel && penable && pwrite && pready;

    always_comb begin
        case (w_reg_idx)
            REG_FREQ_DISTANCES: prdata = r_freq;
            REG_SYNC_DISTANCE:  prdata = {56'b0, r_sync};
            REG_TOLERANCE:      prdata = {60'b0, r_tol};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_DISTANCES_RST;
            r_sync <= SYNC_DISTANCE_RST;
            r_tol  <= TOLERANCE_RST;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_FREQ_DISTANCES: r_freq <= pwdata;
                REG_SYNC_DISTANCE:  r_sync <= pwdata[7:0];
                REG_TOLERANCE:      r_tol  <= pwdata[3:0];
                default:            ;
            endcase
        end
    end

    // Exact class matches win over the exact sync match, which wins over
    // the tolerance windows; anything left over counts as sync.
    always_comb begin
        logic found;
        found   = 1'b0;
        w_class = CLASS_SYNC;
        for (int k = 0; k < 8; k++) begin
            if (!found && dist_equal(r_in.exact_distance, r_freq[8*k +: 8])) begin
                found   = 1'b1;
                w_class = 4'(k + 1);
            end
        end
        if (!found && dist_equal(r_in.exact_distance, r_sync)) begin
            found   = 1'b1;
            w_class = CLASS_SYNC;
        end
        for (int k = 0; k < 8; k++) begin
            if (!found && in_window(r_in.approx_distance, r_freq[8*k +: 8], r_tol)) begin
                found   = 1'b1;
                w_class = 4'(k + 1);
            end
        end
    end

    assign w_pos   = ((r_phase >= PHASE_DIGIT_1) && (r_phase <= PHASE_DIGIT_4)) ?
                     r_phase : PHASE_DIGIT_1;
    assign w_digit = 2'(w_class - 4'd1);
    assign w_sum   = r_acc + (8'(w_digit) << (2 * (3'd4 - w_pos)));

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_last  = r_last;
        w_emit  = 1'b0;
        if (r_phase == PHASE_WAIT_SYNC) begin
            if (dist_equal(r_in.exact_distance, r_sync) ||
                in_window(r_in.approx_distance, r_sync, r_tol)) begin
                n_phase = PHASE_DIGIT_1;
            end
        end else if (w_class != r_last) begin
            n_last = w_class;
            if (w_class == CLASS_SYNC) begin
                n_phase = PHASE_DIGIT_1;
                n_acc   = '0;
            end else if (w_pos != PHASE_DIGIT_4) begin
                n_phase = w_pos + 3'd1;
                n_acc   = w_sum;
            end else begin
                n_phase = PHASE_DIGIT_1;
                n_acc   = '0;
                w_emit  = 1'b1;
            end
        end
    end

    assign w_proc     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PHASE_WAIT_SYNC;
            r_acc       <= '0;
            r_last      <= CLASS_NONE;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_out_valid <= w_emit;
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_last      <= n_last;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_proc && w_emit) begin
            r_out.range_error <= w_sum[7];
            r_out.char_code   <= w_sum[7] ? 7'd0 : w_sum[6:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== verif/fsk_distance_symbol_decoder_tb.sv =====
// ============================================================================
// fsk_distance_symbol_decoder_tb
// Self-checking bench for the distance-coded FSK symbol decoder. Frames of
// stripe distances go in over the valid/stall channel and a local model of
// the decoder predicts each character. Every output transfer is compared
// with the oldest prediction. The stimulus starts with a fixed frame list
// and then sends random symbols, broken symbols and noise under four register
// settings, with random gaps and output stalls in all but the last one.
// ============================================================================
module fsk_distance_symbol_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsk_dec_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    logic [63:0] cfg_freq;
    logic [7:0]  cfg_sync;
    logic [3:0]  cfg_tol;
    logic [2:0]  dec_phase;
    logic [7:0]  dec_acc;
    logic [3:0]  dec_last;

    t_out_item exp_chars[$];
    int        n_frames;
    int        n_chars;
    int        n_range_err;
    int        n_errors;
    int        stall_left;
    bit        idle_on;

    fsk_distance_symbol_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d characters still expected", exp_chars.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic bit near_dist(input logic [DIST_WIDTH-1:0] v, input logic [7:0] c);
        int lo;
        int hi;
        lo = int'(c) - int'(cfg_tol);
        hi = int'(c) + int'(cfg_tol);
        return int'(v) >= lo && int'(v) <= hi;
    endfunction

    function automatic logic [3:0] class_of(input t_in_item f);
        for (int k = 0; k < 8; k++) begin
            if (f.exact_distance == DIST_WIDTH'(cfg_freq[8*k +: 8])) return 4'(k + 1);
        end
        if (f.exact_distance == DIST_WIDTH'(cfg_sync)) return CLASS_SYNC;
        for (int k = 0; k < 8; k++) begin
            if (near_dist(f.approx_distance, cfg_freq[8*k +: 8])) return 4'(k + 1);
        end
        return CLASS_SYNC;
    endfunction

    // Advances the decoder model by one frame; returns 1 when a character completes.
    function automatic bit decode_frame(input t_in_item f, output t_out_item ch);
        logic [3:0] cls;
        logic [7:0] digit;
        ch = '0;
        if (dec_phase == PHASE_WAIT_SYNC) begin
            if (f.exact_distance == DIST_WIDTH'(cfg_sync) ||
                near_dist(f.approx_distance, cfg_sync)) begin
                dec_phase = PHASE_DIGIT_1;
            end
            return 1'b0;
        end
        cls = class_of(f);
        if (cls == dec_last) return 1'b0;
        dec_last = cls;
        if (cls == CLASS_SYNC) begin
            dec_phase = PHASE_DIGIT_1;
            dec_acc   = 8'd0;
            return 1'b0;
        end
        digit   = 8'((cls - 4'd1) & 4'd3);
        dec_acc = dec_acc + (digit << (2 * (4 - int'(dec_phase))));
        if (dec_phase != PHASE_DIGIT_4) begin
            dec_phase = dec_phase + 3'd1;
            return 1'b0;
        end
        ch.range_error = dec_acc[7];
        ch.char_code   = dec_acc[7] ? 7'd0 : dec_acc[6:0];
        dec_phase = PHASE_DIGIT_1;
        dec_acc   = 8'd0;
        return 1'b1;
    endfunction

    function automatic t_in_item class_frame(input logic [3:0] cls);
        t_in_item f;
        int       d;
        int       off;
        d = int'(cfg_freq[8*(cls-1) +: 8]);
        if ($urandom_range(0, 1) == 0) begin
            f.exact_distance  = DIST_WIDTH'(d);
            f.approx_distance = DIST_WIDTH'($urandom_range(0, 4095));
        end else begin
            off = int'($urandom_range(0, 2 * cfg_tol)) - int'(cfg_tol);
            f.exact_distance  = DIST_WIDTH'($urandom_range(256, 4095));
            f.approx_distance = DIST_WIDTH'((d + off < 0) ? 0 : d + off);
        end
        return f;
    endfunction

    // Exact sync, sync inside the window, or a frame far from every distance.
    function automatic t_in_item sync_frame();
        t_in_item f;
        int       off;
        f.exact_distance  = DIST_WIDTH'($urandom_range(256, 4095));
        f.approx_distance = DIST_WIDTH'($urandom_range(300, 4095));
        case ($urandom_range(0, 2))
            0: f.exact_distance = DIST_WIDTH'(cfg_sync);
            1: begin
                off = int'($urandom_range(0, 2 * cfg_tol)) - int'(cfg_tol);
                f.approx_distance = DIST_WIDTH'((int'(cfg_sync) + off < 0) ?
                                                0 : int'(cfg_sync) + off);
            end
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_frame(input t_in_item f);
        t_out_item ch;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_frames++;
        if (decode_frame(f, ch)) begin
            exp_chars = {exp_chars, ch};
            if (ch.range_error) n_range_err++;
        end
    endtask

    task automatic send_pair(input int ex, input int ap);
        t_in_item f;
        f.exact_distance  = DIST_WIDTH'(ex);
        f.approx_distance = DIST_WIDTH'(ap);
        send_frame(f);
    endtask

    // Sends the leading digits of sym, switching class bank to avoid repeats.
    task automatic send_digits(input logic [7:0] sym, input int count);
        logic [1:0] d;
        logic [3:0] cls;
        t_in_item   f;
        for (int i = 3; i > 3 - count; i--) begin
            d   = sym[2*i +: 2];
            cls = 4'(d) + (($urandom_range(0, 1) == 0) ? 4'd1 : 4'd5);
            if (cls == dec_last) cls = (cls > 4'd4) ? cls - 4'd4 : cls + 4'd4;
            f = class_frame(cls);
            send_frame(f);
            if ($urandom_range(0, 7) == 0) send_frame(f);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FREQ_DISTANCES: cfg_freq = val;
            REG_SYNC_DISTANCE:  cfg_sync = val[7:0];
            REG_TOLERANCE:      cfg_tol  = val[3:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [63:0] freq, input logic [7:0] sync,
                               input logic [3:0] tol);
        wait_idle();
        write_reg(REG_FREQ_DISTANCES, freq);
        write_reg(REG_SYNC_DISTANCE, 64'(sync));
        write_reg(REG_TOLERANCE, 64'(tol));
    endtask

    task automatic test_directed_frames();
        send_pair(0, 0);
        send_pair(4095, 4095);
        send_pair(4095, 30);
        send_pair(12, 47);
        send_pair(16, 0);
        send_pair(23, 16);
        send_pair(25, 0);
        send_pair(25, 1234);
        send_pair(4095, 34);
        send_pair(4095, 37);
        send_pair(4095, 41);
        send_pair(4095, 48);
        send_pair(23, 4095);
        send_pair(12, 0);
        send_pair(33, 0);
        send_pair(16, 0);
        send_pair(25, 0);
        send_pair(4095, 46);
        send_pair(29, 4095);
        send_pair(16, 0);
        send_pair(25, 0);
        send_pair(47, 0);
        send_pair(4095, 24);
        send_pair(4095, 4095);
        send_pair(16, 0);
        send_pair(38, 0);
        send_pair(4095, 17);
        send_pair(4095, 39);
    endtask

    task automatic test_random_traffic(input int count, input bit allow_idle);
        int start;
        int r;
        start = n_frames;
        while (n_frames - start < count) begin
            if ((n_frames - start) % 40 < 4) idle_on = allow_idle && ($urandom_range(0, 2) != 0);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                while (dec_phase == PHASE_WAIT_SYNC) send_frame(sync_frame());
                if ($urandom_range(0, 3) == 0) send_frame(sync_frame());
                send_digits(8'($urandom), 4);
            end else if (r < 9) begin
                send_pair($urandom_range(0, 4095), $urandom_range(0, 4095));
            end else begin
                send_digits(8'($urandom), $urandom_range(1, 3));
                send_frame(sync_frame());
            end
        end
    endtask

    task automatic test_sender_pause();
        while (dec_phase == PHASE_WAIT_SYNC) send_frame(sync_frame());
        send_digits(8'($urandom), 4);
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d, range error %0d",
                                          o_out_data.char_code, o_out_data.range_error));
            end else begin
                want = exp_chars.pop_front();
                n_chars++;
                if (o_out_data.char_code !== want.char_code)
                    report_mismatch($sformatf("char_code %0d, expected %0d",
                                              o_out_data.char_code, want.char_code));
                if (o_out_data.range_error !== want.range_error)
                    report_mismatch($sformatf("range_error %0d, expected %0d",
                                              o_out_data.range_error, want.range_error));
            end
        end
    end

    initial begin
        logic [63:0] spaced;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        idle_on     = 1'b0;
        stall_left  = 0;
        n_frames    = 0;
        n_chars     = 0;
        n_range_err = 0;
        n_errors    = 0;
        cfg_freq    = FREQ_DISTANCES_RST;
        cfg_sync    = SYNC_DISTANCE_RST;
        cfg_tol     = TOLERANCE_RST;
        dec_phase   = PHASE_WAIT_SYNC;
        dec_acc     = 8'd0;
        dec_last    = CLASS_NONE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        test_directed_frames();
        test_random_traffic(130, 1'b1);
        test_sender_pause();

        load_config(64'hFFC8_9664_3C1E_0A00, 8'd255, 4'd4);
        test_random_traffic(130, 1'b1);

        spaced = '0;
        spaced[7:0] = 8'($urandom_range(0, 7));
        for (int k = 1; k < 8; k++) spaced[8*k +: 8] = 8'(32 * k + $urandom_range(0, 15));
        load_config(spaced, 8'd0, 4'd15);
        test_random_traffic(130, 1'b1);
        test_sender_pause();

        idle_on = 1'b0;
        load_config({$urandom, $urandom}, 8'($urandom), 4'd0);
        test_random_traffic(130, 1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (exp_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", exp_chars.size()));
        $display("Sent %0d frames under four register settings; checked %0d characters,",
                 n_frames, n_chars);
        $display("%0d of them out of range, with %0d mismatches.", n_range_err, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== fsk_distance_symbol_decoder.f =====
sv/fsk_dec_pkg.sv
sv/fsk_distance_symbol_decoder.sv
verif/fsk_distance_symbol_decoder_tb.sv
